// ===== src/assert_macros.svh =====
// Assertion macros shared by the bitmap transform engine RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define BTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bte_pkg.sv =====
// Package for the bitmap transform engine: sizes, codes, word and config types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bte_pkg;

  localparam int MAX_DIM    = 256;
  localparam int MAX_PIXELS = 65536;

  localparam int DIM_W     = $clog2(MAX_DIM) + 1;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int ADDR_W    = $clog2(MAX_PIXELS);
  localparam int NPIX_W    = ADDR_W + 1;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 32;
  localparam int MODE_W    = 3;
  localparam int DIV_CNT_W = $clog2(DIM_W + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_COPY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CROP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_CCW = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_CW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT_180 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SCALE   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd6;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

  // Effective configuration, dimensions already clamped to 1..MAX_DIM.
  typedef struct packed {
    logic [DIM_W-1:0]   sw;
    logic [DIM_W-1:0]   sh;
    logic [DIM_W-1:0]   ow;
    logic [DIM_W-1:0]   oh;
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] crop_left;
    logic [COORD_W-1:0] crop_top;
    logic [NPIX_W-1:0]  npix;
  } cfg_t;

  typedef struct packed {
    logic pos_clr;
    logic frame_clr;
  } cfg_evt_t;

  // Per-step increments for nearest-neighbor scaling: src_dim = q * out_dim + r.
  typedef struct packed {
    logic [DIM_W-1:0]   q_w;
    logic [COORD_W-1:0] r_w;
    logic [DIM_W-1:0]   q_h;
    logic [COORD_W-1:0] r_h;
  } step_t;

  // Queue entry. A load carries its store address in pos, a fetch {row, col}.
  typedef struct packed {
    logic              is_fetch;
    logic              last;
    logic [ADDR_W-1:0] pos;
    logic [PIX_W-1:0]  data;
  } qent_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/bte_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bte_div import bte_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIM_W-1:0]   dividend,
  input  wire logic [DIM_W-1:0]   divisor,
  output logic                    busy,
  output logic [DIM_W-1:0]        quot,
  output logic [COORD_W-1:0]      rem
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIM_W-1:0]     quot_r;
  logic [COORD_W-1:0]   rem_r;
  logic [DIM_W-1:0]     trial;
  logic [DIM_W-1:0]     diff;
  logic                 ge;
  logic [COORD_W-1:0]   rem_nxt;

  assign busy = (cnt_r != '0);
  assign quot = quot_r;
  assign rem  = rem_r;

  always_comb begin
    trial   = {rem_r, quot_r[DIM_W-1]};
    ge      = (trial >= divisor);
    diff    = trial - divisor;
    rem_nxt = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy) begin
      quot_r <= {quot_r[DIM_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  // A start seen while reset is still applied does not load the counter.
  `BTE_ASSERT_NXT(a_div_start, start && rst_n, busy, "divider did not start")

endmodule

`default_nettype wire

// ===== src/bte_fifo.sv =====
// Short word queue between the front (classify) and back (store access) parts.
// Depends on bte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bte_fifo import bte_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t push_ent,
  input  wire logic  pop,
  output logic       vld,
  output qent_t      head,
  output logic       full
);

  qent_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign vld     = (cnt_r != '0);
  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_ent;
  end

  `BTE_ASSERT_IMP(a_fifo_ovf, push, !full, "word pushed into a full queue")

endmodule

`default_nettype wire

// ===== src/bte_front.sv =====
// Front part: accepts load and fetch words, tracks frame and output position,
// maps each fetch to a source row and column. Depends on bte_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bte_front import bte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t in_item,
  input  wire cfg_t     cfg,
  input  wire cfg_evt_t evt,
  input  wire step_t    step,
  output logic          push,
  output qent_t         ent
);

  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0]   qc_r, qc_nxt, qr_r, qr_nxt;
  logic [COORD_W-1:0] rc_r, rc_nxt, rr_r, rr_nxt;
  logic [ADDR_W-1:0]  ld_cnt_r, ld_cnt_nxt;
  logic               loaded_r, loaded_nxt;

  logic [DIM_W-1:0]   w, h;
  logic [DIM_W-1:0]   sc9, sr9;
  logic [COORD_W-1:0] sc, sr;
  logic               col_end, row_end, last;
  logic [DIM_W-1:0]   rc_sum, rr_sum;
  logic               rc_wrap, rr_wrap;
  logic [NPIX_W-1:0]  ld_inc;
  logic               act;

  // Output geometry and source coordinate of the current output position.
  always_comb begin
    w   = cfg.sw;
    h   = cfg.sh;
    sr9 = DIM_W'(row_r);
    sc9 = DIM_W'(col_r);
    unique case (cfg.mode)
      MODE_CROP: begin
        w   = cfg.ow;
        h   = cfg.oh;
        sc9 = DIM_W'(cfg.crop_left) + DIM_W'(col_r);
        sr9 = DIM_W'(cfg.crop_top) + DIM_W'(row_r);
      end
      MODE_ROT_CCW: begin
        w   = cfg.sh;
        h   = cfg.sw;
        sr9 = DIM_W'(col_r);
        sc9 = cfg.sw - DIM_W'(1) - DIM_W'(row_r);
      end
      MODE_ROT_CW: begin
        w   = cfg.sh;
        h   = cfg.sw;
        sr9 = cfg.sh - DIM_W'(1) - DIM_W'(col_r);
        sc9 = DIM_W'(row_r);
      end
      MODE_ROT_180: begin
        sr9 = cfg.sh - DIM_W'(1) - DIM_W'(row_r);
        sc9 = cfg.sw - DIM_W'(1) - DIM_W'(col_r);
      end
      MODE_SCALE: begin
        w   = cfg.ow;
        h   = cfg.oh;
        sc9 = qc_r;
        sr9 = qr_r;
      end
      default: begin
        sr9 = DIM_W'(row_r);
        sc9 = DIM_W'(col_r);
      end
    endcase
    // Clamp to the last column and row of the source.
    sc = (sc9 >= cfg.sw) ? COORD_W'(cfg.sw - DIM_W'(1)) : sc9[COORD_W-1:0];
    sr = (sr9 >= cfg.sh) ? COORD_W'(cfg.sh - DIM_W'(1)) : sr9[COORD_W-1:0];

    col_end = (DIM_W'(col_r) + DIM_W'(1)) >= w;
    row_end = (DIM_W'(row_r) + DIM_W'(1)) >= h;
    last    = col_end && row_end;

    rc_sum  = DIM_W'(rc_r) + DIM_W'(step.r_w);
    rr_sum  = DIM_W'(rr_r) + DIM_W'(step.r_h);
    rc_wrap = (rc_sum >= cfg.ow);
    rr_wrap = (rr_sum >= cfg.oh);
    ld_inc  = NPIX_W'(ld_cnt_r) + NPIX_W'(1);
  end

  assign act  = accept && !evt.pos_clr;
  assign push = act && ((in_item.cmd == CMD_LOAD) || loaded_r);

  always_comb begin
    ent.is_fetch = (in_item.cmd == CMD_FETCH);
    ent.last     = (in_item.cmd == CMD_FETCH) && last;
    ent.pos      = (in_item.cmd == CMD_FETCH) ? ADDR_W'({sr, sc}) : ld_cnt_r;
    ent.data     = in_item.pixel_in;
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    qc_nxt     = qc_r;
    qr_nxt     = qr_r;
    rc_nxt     = rc_r;
    rr_nxt     = rr_r;
    ld_cnt_nxt = ld_cnt_r;
    loaded_nxt = loaded_r;
    if (evt.pos_clr) begin
      col_nxt = '0;
      row_nxt = '0;
      qc_nxt  = '0;
      qr_nxt  = '0;
      rc_nxt  = '0;
      rr_nxt  = '0;
      if (evt.frame_clr) begin
        ld_cnt_nxt = '0;
        loaded_nxt = 1'b0;
      end
    end else if (act && (in_item.cmd == CMD_LOAD)) begin
      if (ld_cnt_r == '0) loaded_nxt = 1'b0;
      if (ld_inc >= cfg.npix) begin
        ld_cnt_nxt = '0;
        loaded_nxt = 1'b1;
        col_nxt    = '0;
        row_nxt    = '0;
        qc_nxt     = '0;
        qr_nxt     = '0;
        rc_nxt     = '0;
        rr_nxt     = '0;
      end else begin
        ld_cnt_nxt = ld_inc[ADDR_W-1:0];
      end
    end else if (act && loaded_r) begin
      if (col_end) begin
        col_nxt = '0;
        qc_nxt  = '0;
        rc_nxt  = '0;
        if (row_end) begin
          row_nxt = '0;
          qr_nxt  = '0;
          rr_nxt  = '0;
        end else begin
          row_nxt = row_r + COORD_W'(1);
          qr_nxt  = qr_r + step.q_h + DIM_W'(rr_wrap);
          rr_nxt  = rr_wrap ? COORD_W'(rr_sum - cfg.oh) : rr_sum[COORD_W-1:0];
        end
      end else begin
        col_nxt = col_r + COORD_W'(1);
        qc_nxt  = qc_r + step.q_w + DIM_W'(rc_wrap);
        rc_nxt  = rc_wrap ? COORD_W'(rc_sum - cfg.ow) : rc_sum[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      qc_r     <= '0;
      qr_r     <= '0;
      rc_r     <= '0;
      rr_r     <= '0;
      ld_cnt_r <= '0;
      loaded_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      qc_r     <= qc_nxt;
      qr_r     <= qr_nxt;
      rc_r     <= rc_nxt;
      rr_r     <= rr_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  // The final pixel of an image must bring the position back to the origin.
  `BTE_ASSERT_NXT(a_front_wrap, push && ent.last, (col_r == '0) && (row_r == '0),
                  "output position did not wrap after the last pixel")

endmodule

`default_nettype wire

// ===== src/bte_back.sv =====
// Back part: drains the queue, forms store addresses, writes or reads the frame store.
// Depends on bte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bte_back import bte_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             vld,
  input  wire qent_t            head,
  input  wire logic [DIM_W-1:0] sw,
  output logic                  out_valid,
  output out_item_t             out_data
);

  logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];
  logic [COORD_W-1:0] row, col;
  logic [NPIX_W-1:0]  prod;
  logic [ADDR_W-1:0]  addr;

  logic               we_r, re_r, out_valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [PIX_W-1:0]   data_r, rd_r;
  logic               last_r, out_last_r;

  always_comb begin
    row  = head.pos[2*COORD_W-1:COORD_W];
    col  = head.pos[COORD_W-1:0];
    prod = NPIX_W'(row) * NPIX_W'(sw) + NPIX_W'(col);
    addr = head.is_fetch ? prod[ADDR_W-1:0] : head.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_r        <= 1'b0;
      re_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      we_r        <= vld && !head.is_fetch;
      re_r        <= vld && head.is_fetch;
      out_valid_r <= re_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr;
    data_r     <= head.data;
    last_r     <= head.last;
    out_last_r <= last_r;
  end

  always_ff @(posedge clk) begin
    if (we_r) frame_mem[addr_r] <= data_r;
    if (re_r) rd_r <= frame_mem[addr_r];
  end

  assign out_valid           = out_valid_r;
  assign out_data.pixel_out  = rd_r;
  assign out_data.frame_last = out_last_r;

  `BTE_ASSERT(a_back_excl, !(we_r && re_r), "store written and read in one cycle")

endmodule

`default_nettype wire

// ===== src/bitmap_transform_engine.sv =====
// Bitmap transform engine: the port takes a load word or a fetch word, and start is
// taken on any cycle in which busy is low. A fetch result shows on out_valid after
// its word passes the queue, the registered address multiply and the registered
// frame store read. Results cannot be held off. After reset and after every
// configuration write, busy stays high while the serial dividers launch and then
// work out the nine quotient bits of the per-pixel steps of the scale mode.
// Fetches issued before a full frame is loaded give no word.
// Depends on bte_pkg, bte_div, bte_fifo, bte_front, bte_back and assert_macros.svh.
`default_nettype none

module bitmap_transform_engine import bte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [DIM_W-1:0]   src_width_r, src_height_r, out_width_r, out_height_r;
  logic [MODE_W-1:0]  op_mode_r;
  logic [COORD_W-1:0] crop_left_r, crop_top_r;
  logic [NPIX_W-1:0]  npix_r;
  logic               pend_r;

  cfg_t     cfg;
  cfg_evt_t evt;
  step_t    step;
  logic     accept;
  logic     dw_busy, dh_busy;
  logic     push, fifo_vld, fifo_full;
  qent_t    push_ent, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(1);
      src_height_r <= DIM_W'(1);
      op_mode_r    <= MODE_COPY;
      crop_left_r  <= '0;
      crop_top_r   <= '0;
      out_width_r  <= DIM_W'(1);
      out_height_r <= DIM_W'(1);
      pend_r       <= 1'b1;
    end else begin
      pend_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
          REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
          REG_OP_MODE:    op_mode_r    <= cfg_wdata[MODE_W-1:0];
          REG_CROP_LEFT:  crop_left_r  <= cfg_wdata[COORD_W-1:0];
          REG_CROP_TOP:   crop_top_r   <= cfg_wdata[COORD_W-1:0];
          REG_OUT_WIDTH:  out_width_r  <= cfg_wdata;
          REG_OUT_HEIGHT: out_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.sw        = eff_dim(src_width_r);
    cfg.sh        = eff_dim(src_height_r);
    cfg.ow        = eff_dim(out_width_r);
    cfg.oh        = eff_dim(out_height_r);
    // Unused mode codes behave as a plain copy.
    cfg.mode      = (op_mode_r > MODE_SCALE) ? MODE_COPY : op_mode_r;
    cfg.crop_left = crop_left_r;
    cfg.crop_top  = crop_top_r;
    cfg.npix      = npix_r;
  end

  always_ff @(posedge clk) begin
    npix_r <= NPIX_W'(cfg.sw) * NPIX_W'(cfg.sh);
  end

  assign evt.pos_clr   = cfg_we && (cfg_idx <= REG_OUT_HEIGHT);
  assign evt.frame_clr = cfg_we && ((cfg_idx == REG_SRC_WIDTH) ||
                                    (cfg_idx == REG_SRC_HEIGHT));

  assign busy   = pend_r || dw_busy || dh_busy || fifo_full;
  assign accept = start && !busy;

  bte_div u_div_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pend_r),
    .dividend (cfg.sw),
    .divisor  (cfg.ow),
    .busy     (dw_busy),
    .quot     (step.q_w),
    .rem      (step.r_w)
  );

  bte_div u_div_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pend_r),
    .dividend (cfg.sh),
    .divisor  (cfg.oh),
    .busy     (dh_busy),
    .quot     (step.q_h),
    .rem      (step.r_h)
  );

  bte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .cfg     (cfg),
    .evt     (evt),
    .step    (step),
    .push    (push),
    .ent     (push_ent)
  );

  bte_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (fifo_vld),
    .vld      (fifo_vld),
    .head     (head),
    .full     (fifo_full)
  );

  bte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (fifo_vld),
    .head      (head),
    .sw        (cfg.sw),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
